>>> rtl/core/hidrdp_pkg.sv
// ----------------------------------------------------------------------------
// hidrdp_pkg
// Types and constants shared by the HID report descriptor parser modules.
// ----------------------------------------------------------------------------
package hidrdp_pkg;

    localparam logic [7:0] PREFIX_LONG = 8'hFE;

    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    localparam logic [3:0] TAG_INPUT      = 4'd8;
    localparam logic [3:0] TAG_COLLECTION = 4'd10;
    localparam logic [3:0] TAG_END_COLL   = 4'd12;

    localparam logic [3:0] TAG_USAGE_PAGE = 4'd0;
    localparam logic [3:0] TAG_LOG_MIN    = 4'd1;
    localparam logic [3:0] TAG_LOG_MAX    = 4'd2;
    localparam logic [3:0] TAG_RPT_SIZE   = 4'd7;
    localparam logic [3:0] TAG_RPT_ID     = 4'd8;
    localparam logic [3:0] TAG_RPT_COUNT  = 4'd9;
    localparam logic [3:0] TAG_PUSH       = 4'd10;
    localparam logic [3:0] TAG_POP        = 4'd11;

    localparam logic [3:0] TAG_USAGE     = 4'd0;
    localparam logic [3:0] TAG_USAGE_MIN = 4'd1;
    localparam logic [3:0] TAG_USAGE_MAX = 4'd2;

    localparam logic [15:0] PAGE_GENERIC_DESKTOP = 16'h0001;
    localparam logic [15:0] APP_JOYSTICK         = 16'h0004;
    localparam logic [15:0] APP_GAMEPAD          = 16'h0005;
    localparam logic [15:0] APP_MULTI_AXIS       = 16'h0008;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SHORT = 4'b0010,
        PH_LHDR  = 4'b0100,
        PH_LDATA = 4'b1000
    } asm_phase_t;

    // One complete short item, valid in the cycle its last byte is taken.
    typedef struct packed {
        logic        fire;
        logic [7:0]  prefix;
        logic [2:0]  need;
        logic [31:0] data;
    } item_t;

    typedef struct packed {
        logic [15:0] usage_page;
        logic [31:0] lmin;
        logic [31:0] lmax;
        logic [7:0]  rsize;
        logic [7:0]  rid;
        logic [7:0]  rcount;
    } gstate_t;

endpackage

>>> rtl/core/hidrdp_asm.sv
// ----------------------------------------------------------------------------
// hidrdp_asm
// Item assembler: collects short item data bytes and skips long items.
// ----------------------------------------------------------------------------
module hidrdp_asm (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  logic [7:0]         din,
    input  logic               clear,
    output hidrdp_pkg::item_t  item
);

    hidrdp_pkg::asm_phase_t phase_reg, phase_next;
    logic [7:0]  prefix_reg, prefix_next;
    logic [7:0]  need_reg, need_next;
    logic [7:0]  got_reg, got_next;
    logic [31:0] data_reg, data_next;
    logic [2:0]  need_b;
    logic [31:0] shifted;

    always_comb begin
        need_b = (din[1:0] == 2'd3) ? 3'd4 : {1'b0, din[1:0]};
        unique case (got_reg[1:0])
            2'd0: shifted = {24'd0, din};
            2'd1: shifted = {16'd0, din, 8'd0};
            2'd2: shifted = {8'd0, din, 16'd0};
            default: shifted = {din, 24'd0};
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        need_next   = need_reg;
        got_next    = got_reg;
        data_next   = data_reg;
        item.fire   = 1'b0;
        item.prefix = prefix_reg;
        item.need   = need_reg[2:0];
        item.data   = data_reg;
        unique case (phase_reg)
            hidrdp_pkg::PH_IDLE: begin
                got_next = 8'd0;
                if (din == hidrdp_pkg::PREFIX_LONG) begin
                    phase_next = hidrdp_pkg::PH_LHDR;
                end else begin
                    prefix_next = din;
                    need_next   = {5'd0, need_b};
                    data_next   = 32'd0;
                    item.prefix = din;
                    item.need   = need_b;
                    item.data   = 32'd0;
                    if (need_b == 3'd0) begin
                        item.fire = take;
                    end else begin
                        phase_next = hidrdp_pkg::PH_SHORT;
                    end
                end
            end
            hidrdp_pkg::PH_SHORT: begin
                data_next = data_reg | shifted;
                got_next  = got_reg + 8'd1;
                item.data = data_next;
                if (got_next >= need_reg) begin
                    phase_next = hidrdp_pkg::PH_IDLE;
                    item.fire  = take;
                end
            end
            hidrdp_pkg::PH_LHDR: begin
                if (got_reg == 8'd0) begin
                    need_next = din;
                    got_next  = 8'd1;
                end else begin
                    got_next   = 8'd0;
                    phase_next = (need_reg == 8'd0) ? hidrdp_pkg::PH_IDLE
                                                    : hidrdp_pkg::PH_LDATA;
                end
            end
            default: begin
                got_next = got_reg + 8'd1;
                if (got_next >= need_reg) begin
                    phase_next = hidrdp_pkg::PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && clear)) begin
            phase_reg  <= hidrdp_pkg::PH_IDLE;
            prefix_reg <= 8'd0;
            need_reg   <= 8'd0;
            got_reg    <= 8'd0;
            data_reg   <= 32'd0;
        end else if (take) begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            need_reg   <= need_next;
            got_reg    <= got_next;
            data_reg   <= data_next;
        end
    end

endmodule

>>> rtl/core/hid_report_descriptor_parser_top.sv
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser_top
// HID report descriptor parser emitting game controller field records.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one descriptor byte per request in s_tdata, s_tlast marks the
//   final byte of the descriptor. m_axis: field records (m_tuser = 0) and one
//   summary record (m_tuser = 1) after the final byte; m_tlast flags the last
//   record caused by a byte.
// Sequence:
//   A data byte that completes no item goes from idle to finish. A completed
//   item passes through offset and usage list read, execute and finish. An
//   Input item that walks its elements adds a usage lookup and an emit step
//   per element through the shared offset adder and usage lookup; s_tready
//   stays low meanwhile. The final byte loads the summary record in its
//   finish state, which holds while the output register is still full.
// Reset:
//   aresetn clears all parser state; per-report offsets use 256 valid bits
//   cleared together, so no clearing pass is needed. The same clear is
//   applied whenever a summary record is loaded.
// Stall:
//   A record waits in the output register while m_tready is low; the
//   sequencer holds until the register frees up.
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser_top #(
    parameter int MAX_FIELD_RECORDS = 32,
    parameter int STACK_DEPTH       = 4,
    parameter int LOCAL_USAGE_DEPTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] descriptor_byte
    input  logic         s_tlast,   // end_of_descriptor
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] report_number, [23:8] bit_position, [29:24] bit_width,
    // [45:30] usage_page_out, [61:46] usage_out, [93:62] logical_minimum,
    // [125:94] logical_maximum, [126] gamepad_found, [132:127] fields_total
    output logic [135:0] m_tdata,
    output logic         m_tuser,   // record_kind
    output logic         m_tlast    // last_result
);

    localparam int UAW = (LOCAL_USAGE_DEPTH > 1) ? $clog2(LOCAL_USAGE_DEPTH) : 1;
    localparam int UCW = $clog2(LOCAL_USAGE_DEPTH + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam logic [UCW-1:0] UDEPTH = UCW'(LOCAL_USAGE_DEPTH);
    localparam logic [SCW-1:0] SDEPTH = SCW'(STACK_DEPTH);
    localparam logic [5:0]     MAXREC = 6'(MAX_FIELD_RECORDS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_ULOOK = 6'b001000,
        S_EMIT  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg;

    hidrdp_pkg::item_t   item;
    hidrdp_pkg::item_t   item_reg;
    hidrdp_pkg::gstate_t glob_reg;
    hidrdp_pkg::gstate_t stack_reg [STACK_DEPTH];
    logic [SCW-1:0]      scnt_reg;
    logic                last_reg;

    logic [15:0]    usage_mem [LOCAL_USAGE_DEPTH];
    logic [15:0]    usage_rd_reg;
    logic [UCW-1:0] ucnt_reg;
    logic           has_umin_reg, has_umax_reg;
    logic [15:0]    umin_reg, umax_reg;

    logic [15:0]  off_mem [256];
    logic [255:0] off_vld_reg;
    logic [15:0]  off_q_reg;
    logic         off_q_vld_reg;
    logic [15:0]  off_cur_reg;

    logic [7:0]  coll_depth_reg, pad_depth_reg;
    logic        res_gp_reg;
    logic [5:0]  res_cnt_reg;
    logic [15:0] res_page_reg, res_usage_reg;
    logic [7:0]  idx_reg;

    logic         m_tvalid_reg;
    logic [135:0] m_tdata_reg;
    logic         m_tuser_reg, m_tlast_reg;

    logic        s_take, out_free, clear_all;
    logic [1:0]  itype;
    logic [3:0]  itag;
    logic [31:0] uv, sv;
    logic [15:0] off_eff, usage_val, umin_i;
    logic [UAW-1:0] uaddr;
    logic        idx_in_list, emit_ok, input_walk, is_pad_coll, last_elem;
    logic        local_clr, off_wr;
    logic [15:0] off_wdata;
    logic [15:0] size_x_count;

    assign s_take   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    hidrdp_asm u_asm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (s_take),
        .din     (s_tdata),
        .clear   (s_tlast),
        .item    (item)
    );

    // Item decode and data extension.
    always_comb begin
        itype = item_reg.prefix[3:2];
        itag  = item_reg.prefix[7:4];
        uv    = item_reg.data;
        sv    = uv;
        if (item_reg.need == 3'd1 && uv[7]) begin
            sv = uv | 32'hFFFFFF00;
        end else if (item_reg.need == 3'd2 && uv[15]) begin
            sv = uv | 32'hFFFF0000;
        end
    end

    // Shared usage lookup for element idx_reg.
    always_comb begin
        idx_in_list = {1'b0, idx_reg} < 9'(ucnt_reg);
        umin_i      = umin_reg + {8'd0, idx_reg};
        uaddr       = idx_in_list ? idx_reg[UAW-1:0] : UAW'(ucnt_reg - UCW'(1));
        if (idx_in_list) begin
            usage_val = usage_rd_reg;
        end else if (has_umin_reg && has_umax_reg && umin_i <= umax_reg) begin
            usage_val = umin_i;
        end else if (ucnt_reg != '0) begin
            usage_val = usage_rd_reg;
        end else begin
            usage_val = 16'd0;
        end
    end

    always_comb begin
        off_eff      = off_q_vld_reg ? off_q_reg : 16'd0;
        size_x_count = 16'(glob_reg.rsize) * 16'(glob_reg.rcount);
        emit_ok      = (res_cnt_reg < MAXREC) && (glob_reg.rsize != 8'd0)
                       && (glob_reg.rsize <= 8'd32);
        input_walk   = (pad_depth_reg != 8'd0) && !uv[0] && uv[1]
                       && (glob_reg.rcount != 8'd0);
        is_pad_coll  = (coll_depth_reg == 8'd0)
                       && (glob_reg.usage_page == hidrdp_pkg::PAGE_GENERIC_DESKTOP)
                       && (usage_val == hidrdp_pkg::APP_JOYSTICK
                           || usage_val == hidrdp_pkg::APP_GAMEPAD
                           || usage_val == hidrdp_pkg::APP_MULTI_AXIS);
        last_elem    = (idx_reg + 8'd1) == glob_reg.rcount;
        clear_all    = (state_reg == S_FIN) && last_reg && out_free;
        local_clr    = 1'b0;
        off_wr       = 1'b0;
        off_wdata    = off_cur_reg + {8'd0, glob_reg.rsize};
        if (state_reg == S_EXEC && itype == hidrdp_pkg::TYPE_MAIN) begin
            local_clr = !(itag == hidrdp_pkg::TAG_INPUT && input_walk);
            if (itag == hidrdp_pkg::TAG_INPUT && !input_walk) begin
                off_wr    = 1'b1;
                off_wdata = off_eff + size_x_count;
            end
        end
        if (state_reg == S_EMIT && (out_free || !emit_ok) && last_elem) begin
            local_clr = 1'b1;
            off_wr    = 1'b1;
        end
    end

    // Usage list memory: undefined until written.
    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC && itype == hidrdp_pkg::TYPE_LOCAL
            && itag == hidrdp_pkg::TAG_USAGE && ucnt_reg < UDEPTH) begin
            usage_mem[ucnt_reg[UAW-1:0]] <= uv[15:0];
        end
        usage_rd_reg <= usage_mem[uaddr];
    end

    // Per-report offset memory; valid bits stand in for the zero reset.
    always_ff @(posedge aclk) begin
        if (off_wr) begin
            off_mem[glob_reg.rid] <= off_wdata;
        end
        if (state_reg == S_READ) begin
            off_q_reg <= off_mem[glob_reg.rid];
        end
    end

    // Sequencer and parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            glob_reg       <= '0;
            scnt_reg       <= '0;
            last_reg       <= 1'b0;
            ucnt_reg       <= '0;
            has_umin_reg   <= 1'b0;
            has_umax_reg   <= 1'b0;
            umin_reg       <= 16'd0;
            umax_reg       <= 16'd0;
            off_vld_reg    <= '0;
            off_q_vld_reg  <= 1'b0;
            off_cur_reg    <= 16'd0;
            coll_depth_reg <= 8'd0;
            pad_depth_reg  <= 8'd0;
            res_gp_reg     <= 1'b0;
            res_cnt_reg    <= 6'd0;
            res_page_reg   <= 16'd0;
            res_usage_reg  <= 16'd0;
            idx_reg        <= 8'd0;
        end else begin
            if (off_wr) begin
                off_vld_reg[glob_reg.rid] <= 1'b1;
            end
            if (local_clr) begin
                ucnt_reg     <= '0;
                has_umin_reg <= 1'b0;
                has_umax_reg <= 1'b0;
                umin_reg     <= 16'd0;
                umax_reg     <= 16'd0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_take) begin
                        last_reg  <= s_tlast;
                        item_reg  <= item;
                        idx_reg   <= 8'd0;
                        state_reg <= item.fire ? S_READ : S_FIN;
                    end
                end
                S_READ: begin
                    // Fetch the offset and first usage for this item.
                    off_q_vld_reg <= off_vld_reg[glob_reg.rid];
                    state_reg     <= S_EXEC;
                end
                S_EXEC: begin
                    // Walk the elements of a qualifying Input item, else finish.
                    state_reg <= (itype == hidrdp_pkg::TYPE_MAIN
                                  && itag == hidrdp_pkg::TAG_INPUT && input_walk)
                                 ? S_ULOOK : S_FIN;
                    unique case (itype)
                        hidrdp_pkg::TYPE_MAIN: begin
                            if (itag == hidrdp_pkg::TAG_INPUT) begin
                                if (input_walk) begin
                                    off_cur_reg <= off_eff;
                                end
                            end else if (itag == hidrdp_pkg::TAG_COLLECTION) begin
                                if (is_pad_coll) begin
                                    res_gp_reg    <= 1'b1;
                                    res_page_reg  <= glob_reg.usage_page;
                                    res_usage_reg <= usage_val;
                                    pad_depth_reg <= coll_depth_reg + 8'd1;
                                end
                                coll_depth_reg <= coll_depth_reg + 8'd1;
                            end else if (itag == hidrdp_pkg::TAG_END_COLL) begin
                                if (coll_depth_reg == pad_depth_reg) begin
                                    pad_depth_reg <= 8'd0;
                                end
                                if (coll_depth_reg != 8'd0) begin
                                    coll_depth_reg <= coll_depth_reg - 8'd1;
                                end
                            end
                        end
                        hidrdp_pkg::TYPE_GLOBAL: begin
                            unique case (itag)
                                hidrdp_pkg::TAG_USAGE_PAGE: glob_reg.usage_page <= uv[15:0];
                                hidrdp_pkg::TAG_LOG_MIN:    glob_reg.lmin <= sv;
                                hidrdp_pkg::TAG_LOG_MAX:
                                    glob_reg.lmax <= glob_reg.lmin[31] ? sv : uv;
                                hidrdp_pkg::TAG_RPT_SIZE:   glob_reg.rsize  <= uv[7:0];
                                hidrdp_pkg::TAG_RPT_ID:     glob_reg.rid    <= uv[7:0];
                                hidrdp_pkg::TAG_RPT_COUNT:  glob_reg.rcount <= uv[7:0];
                                hidrdp_pkg::TAG_PUSH: begin
                                    if (scnt_reg < SDEPTH) begin
                                        stack_reg[scnt_reg[SAW-1:0]] <= glob_reg;
                                        scnt_reg <= scnt_reg + SCW'(1);
                                    end
                                end
                                hidrdp_pkg::TAG_POP: begin
                                    if (scnt_reg != '0) begin
                                        glob_reg <= stack_reg[SAW'(scnt_reg - SCW'(1))];
                                        scnt_reg <= scnt_reg - SCW'(1);
                                    end
                                end
                                default: ;
                            endcase
                        end
                        hidrdp_pkg::TYPE_LOCAL: begin
                            if (itag == hidrdp_pkg::TAG_USAGE) begin
                                if (ucnt_reg < UDEPTH) begin
                                    ucnt_reg <= ucnt_reg + UCW'(1);
                                end
                            end else if (itag == hidrdp_pkg::TAG_USAGE_MIN) begin
                                has_umin_reg <= 1'b1;
                                umin_reg     <= uv[15:0];
                            end else if (itag == hidrdp_pkg::TAG_USAGE_MAX) begin
                                has_umax_reg <= 1'b1;
                                umax_reg     <= uv[15:0];
                            end
                        end
                        default: ;
                    endcase
                end
                S_ULOOK: begin
                    // Usage entry for idx_reg is read this cycle.
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    // Hold while a record is due and the output is full.
                    if (out_free || !emit_ok) begin
                        if (emit_ok) begin
                            res_cnt_reg <= res_cnt_reg + 6'd1;
                        end
                        off_cur_reg <= off_wdata;
                        idx_reg     <= idx_reg + 8'd1;
                        state_reg   <= last_elem ? S_FIN : S_ULOOK;
                    end
                end
                S_FIN: begin
                    // Summary path is handled by clear_all.
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && emit_ok && out_free) begin
            m_tvalid_reg <= 1'b1;
            m_tuser_reg  <= 1'b0;
            m_tlast_reg  <= (last_elem || (res_cnt_reg + 6'd1) == MAXREC)
                            && !last_reg;
            m_tdata_reg  <= {3'd0, 6'd0, 1'b0, glob_reg.lmax, glob_reg.lmin,
                             usage_val, glob_reg.usage_page,
                             glob_reg.rsize[5:0], off_cur_reg, glob_reg.rid};
        end else if (clear_all) begin
            m_tvalid_reg <= 1'b1;
            m_tuser_reg  <= 1'b1;
            m_tlast_reg  <= 1'b1;
            m_tdata_reg  <= {3'd0, res_cnt_reg,
                             res_gp_reg && (res_cnt_reg != 6'd0),
                             32'd0, 32'd0, res_usage_reg, res_page_reg,
                             6'd0, 16'd0, 8'd0};
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
